>>> rtl/core/fcem_pkg.sv
// ----------------------------------------------------------------------------
// fcem_pkg
// Shared types, widths and constants of the fuel cell energy monitor.
// ----------------------------------------------------------------------------
package fcem_pkg;

  // moving average window
  localparam int unsigned WINDOW = 10;

  // field widths
  localparam int unsigned POWER_W   = 26;
  localparam int unsigned PRODUCT_W = 32;
  localparam int unsigned PCT_W     = 14;
  localparam int unsigned ENERGY_W  = 16;
  localparam int unsigned TIME_W    = 28;
  localparam int unsigned PCT_NUM_W = 30;

  // ring bookkeeping
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = POWER_W + CNT_W;

  // serial divider
  localparam int unsigned DIV_NUM_W = 38;
  localparam int unsigned DIV_DEN_W = 26;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // scale factors and limits
  localparam int unsigned POWER_SCALE = 100;
  localparam int unsigned PCT_FULL    = 10000;
  localparam int unsigned MS_PER_HOUR = 3600000;
  localparam int unsigned AVG_MIN_MW  = 1000;
  localparam int unsigned TIME_MAX    = (1 << TIME_W) - 1;

  // reciprocal multipliers, exact for any 32-bit dividend
  localparam logic [31:0] POWER_RECIP  = 32'h51EB851F;
  localparam int unsigned POWER_SHIFT  = 37;
  localparam logic [31:0] ENERGY_RECIP = 32'hD1B71759;
  localparam int unsigned ENERGY_SHIFT = 45;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ENERGY     = 3'd0,
    CFG_PRESSURE_EMPTY = 3'd1,
    CFG_PRESSURE_FULL  = 3'd2,
    CFG_TEMP_LIMIT     = 3'd3,
    CFG_LOW_VOLTAGE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NORMAL      = 2'd0,
    ST_FAULT       = 2'd1,
    ST_HIGH_TEMP   = 2'd2,
    ST_LOW_VOLTAGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PCLASS_EMPTY,
    PCLASS_MID,
    PCLASS_FULL
  } pct_class_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PWR,
    B_RING,
    B_AVG,
    B_PCT_GO,
    B_PCT,
    B_ENG_GO,
    B_ENG,
    B_TIM_GO,
    B_TIM,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [15:0]        voltage_mv;
    logic [15:0]        current_ca;
    logic [15:0]        pressure_cbar;
    logic signed [11:0] temperature_ddeg;
    logic [31:0]        fault_bits;
  } fcem_in_t;

  typedef struct packed {
    logic [POWER_W-1:0]  power_mw;
    logic [POWER_W-1:0]  avg_power_mw;
    logic [PCT_W-1:0]    percent_x100;
    logic [ENERGY_W-1:0] remaining_energy_wh;
    logic [TIME_W-1:0]   remaining_time_s;
    logic [1:0]          status_code;
    logic                temp_alert;
  } fcem_out_t;

  typedef struct packed {
    logic [15:0]        max_energy_wh;
    logic [15:0]        pressure_empty_cbar;
    logic [15:0]        pressure_full_cbar;
    logic signed [11:0] temp_limit_ddeg;
    logic [15:0]        low_voltage_mv;
  } fcem_cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [PRODUCT_W-1:0] product;
    pct_class_e           pclass;
    logic [15:0]          pdiff;
    status_e              status;
    logic                 hot;
  } fcem_job_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } fcem_div_req_t;

endpackage

>>> rtl/core/fcem_div.sv
// ----------------------------------------------------------------------------
// fcem_div
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module fcem_div import fcem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcem_div_req_t        req_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // one shift and trial subtract
  assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = DIV_CNT_W'(DIV_NUM_W);
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
    end else if (cnt_q != '0) begin
      rem_d  = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : DIV_DEN_W'(rem_sh);
      quo_d  = {quo_q[DIV_NUM_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/core/fcem_queue.sv
// ----------------------------------------------------------------------------
// fcem_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module fcem_queue import fcem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fcem_job_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output fcem_job_t rdata_o,
  output logic      empty_o
);

  fcem_job_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/fcem_front.sv
// ----------------------------------------------------------------------------
// fcem_front
// Accepts samples, forms the raw power product, status and pressure class.
// ----------------------------------------------------------------------------
module fcem_front import fcem_pkg::*; (
  input  logic      push_i,
  input  fcem_in_t  in_data_i,
  input  fcem_cfg_t cfg_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output fcem_job_t job_o
);

  logic hot;

  assign q_push_o = push_i && !q_full_i;
  assign hot      = in_data_i.temperature_ddeg > cfg_i.temp_limit_ddeg;

  always_comb begin
    // raw product, scaled down in the back
    job_o.product = {16'd0, in_data_i.voltage_mv} * {16'd0, in_data_i.current_ca};
    job_o.pdiff   = in_data_i.pressure_cbar - cfg_i.pressure_empty_cbar;
    job_o.hot     = hot;

    // pressure class, empty test first
    if (in_data_i.pressure_cbar <= cfg_i.pressure_empty_cbar) begin
      job_o.pclass = PCLASS_EMPTY;
    end else if (in_data_i.pressure_cbar >= cfg_i.pressure_full_cbar) begin
      job_o.pclass = PCLASS_FULL;
    end else begin
      job_o.pclass = PCLASS_MID;
    end

    // prioritized status
    if (in_data_i.fault_bits != '0) begin
      job_o.status = ST_FAULT;
    end else if (hot) begin
      job_o.status = ST_HIGH_TEMP;
    end else if (in_data_i.voltage_mv < cfg_i.low_voltage_mv) begin
      job_o.status = ST_LOW_VOLTAGE;
    end else begin
      job_o.status = ST_NORMAL;
    end
  end

endmodule

>>> rtl/core/fcem_back.sv
// ----------------------------------------------------------------------------
// fcem_back
// Sequencer: power and energy by reciprocal multiply; ring average, percent
// and remaining time over one shared divider, then the result register.
// ----------------------------------------------------------------------------
module fcem_back import fcem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fcem_cfg_t cfg_i,
  input  logic      q_empty_i,
  input  fcem_job_t q_rdata_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output fcem_out_t out_data_o
);

  back_state_e            state_q, state_d;
  fcem_job_t              job_q, job_d;
  logic [POWER_W-1:0]     power_q, power_d;
  logic [POWER_W-1:0]     avg_q, avg_d;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic [PCT_NUM_W-1:0]   eng_num_q, eng_num_d;
  logic [ENERGY_W-1:0]    energy_q, energy_d;
  logic [TIME_W-1:0]      time_q, time_d;
  logic [POWER_W-1:0]     ring_q [WINDOW];
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  fcem_out_t              res_q, res_d;
  logic                   res_valid_q, res_valid_d;
  logic                   ring_we;
  logic                   res_free;
  logic                   win_full;
  logic [POWER_W-1:0]     oldest;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W-1:0]       cnt_new;
  logic [15:0]            pct_den;
  logic [PCT_NUM_W-1:0]   pct_num;
  logic [PCT_NUM_W-1:0]   eng_num;
  logic [DIV_NUM_W-1:0]   time_num;
  logic [PRODUCT_W+31:0]  pwr_prod;
  logic [PCT_NUM_W+31:0]  eng_prod;
  fcem_div_req_t          div_req;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quot;

  fcem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // ring sum update, oldest entry leaves once the window is full
  assign win_full = (cnt_q == CNT_W'(WINDOW));
  assign oldest   = win_full ? ring_q[ptr_q] : '0;
  assign sum_new  = sum_q - SUM_W'(oldest) + SUM_W'(power_q);
  assign cnt_new  = win_full ? cnt_q : cnt_q + 1'b1;

  // constant divisions by reciprocal multiply
  assign pwr_prod = {{32{1'b0}}, job_q.product} * {{PRODUCT_W{1'b0}}, POWER_RECIP};
  assign eng_prod = {{32{1'b0}}, eng_num_q} * {{PCT_NUM_W{1'b0}}, ENERGY_RECIP};

  // operands of the later divisions
  assign pct_den  = cfg_i.pressure_full_cbar - cfg_i.pressure_empty_cbar;
  assign pct_num  = PCT_NUM_W'(job_q.pdiff) * PCT_NUM_W'(PCT_FULL);
  assign eng_num  = PCT_NUM_W'(cfg_i.max_energy_wh) * PCT_NUM_W'(pct_q);
  assign time_num = DIV_NUM_W'(energy_q) * DIV_NUM_W'(MS_PER_HOUR);

  assign res_free = !res_valid_q || pop_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    power_d     = power_q;
    avg_d       = avg_q;
    pct_d       = pct_q;
    eng_num_d   = eng_num_q;
    energy_d    = energy_q;
    time_d      = time_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    ring_we     = 1'b0;
    q_pop_o     = 1'b0;
    div_req     = '0;

    if (res_valid_q && pop_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_rdata_i;
          state_d = B_PWR;
        end
      end
      B_PWR: begin
        power_d = pwr_prod[POWER_SHIFT +: POWER_W];
        state_d = B_RING;
      end
      B_RING: begin
        ring_we       = 1'b1;
        sum_d         = sum_new;
        cnt_d         = cnt_new;
        ptr_d         = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(sum_new);
        div_req.den   = DIV_DEN_W'(cnt_new);
        state_d       = B_AVG;
      end
      B_AVG: begin
        if (div_done) begin
          avg_d   = div_quot[POWER_W-1:0];
          state_d = B_PCT_GO;
        end
      end
      B_PCT_GO: begin
        case (job_q.pclass)
          PCLASS_MID: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(pct_num);
            div_req.den   = DIV_DEN_W'(pct_den);
            state_d       = B_PCT;
          end
          PCLASS_FULL: begin
            pct_d   = PCT_W'(PCT_FULL);
            state_d = B_ENG_GO;
          end
          default: begin
            pct_d   = '0;
            state_d = B_ENG_GO;
          end
        endcase
      end
      B_PCT: begin
        if (div_done) begin
          pct_d   = div_quot[PCT_W-1:0];
          state_d = B_ENG_GO;
        end
      end
      B_ENG_GO: begin
        eng_num_d = eng_num;
        state_d   = B_ENG;
      end
      B_ENG: begin
        energy_d = eng_prod[ENERGY_SHIFT +: ENERGY_W];
        state_d  = B_TIM_GO;
      end
      B_TIM_GO: begin
        if (avg_q <= POWER_W'(AVG_MIN_MW)) begin
          time_d  = '0;
          state_d = B_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = time_num;
          div_req.den   = DIV_DEN_W'(avg_q);
          state_d       = B_TIM;
        end
      end
      B_TIM: begin
        if (div_done) begin
          if (|div_quot[DIV_NUM_W-1:TIME_W]) begin
            time_d = TIME_W'(TIME_MAX);
          end else begin
            time_d = div_quot[TIME_W-1:0];
          end
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (res_free) begin
          res_d.power_mw            = power_q;
          res_d.avg_power_mw        = avg_q;
          res_d.percent_x100        = pct_q;
          res_d.remaining_energy_wh = energy_q;
          res_d.remaining_time_s    = time_q;
          res_d.status_code         = job_q.status;
          res_d.temp_alert          = job_q.hot;
          res_valid_d               = 1'b1;
          state_d                   = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    power_q   <= power_d;
    avg_q     <= avg_d;
    pct_q     <= pct_d;
    eng_num_q <= eng_num_d;
    energy_q  <= energy_d;
    time_q    <= time_d;
    res_q     <= res_d;
    if (ring_we) begin
      ring_q[ptr_q] <= power_q;
    end
  end

  assign empty_o    = !res_valid_q;
  assign out_data_o = res_q;

endmodule

>>> rtl/core/fuel_cell_energy_monitor_unit.sv
// ----------------------------------------------------------------------------
// fuel_cell_energy_monitor_unit
// From accept to result, the word passes the serial divider three times
// (average, percent, time) around the sequencer steps; a clamped percent or a
// zero time skips its pass. The back takes one word at a time; meanwhile
// a two-entry queue takes samples while the back works or a result waits.
// Reset clears queue, ring count, sum and result valid; config takes defaults.
// ----------------------------------------------------------------------------
module fuel_cell_energy_monitor_unit import fcem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  fcem_in_t             in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output fcem_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  fcem_cfg_t cfg_q, cfg_d;
  logic      q_push, q_full, q_pop, q_empty;
  fcem_job_t q_wdata, q_rdata;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ENERGY:     cfg_d.max_energy_wh       = cfg_wdata_i;
        CFG_PRESSURE_EMPTY: cfg_d.pressure_empty_cbar = cfg_wdata_i;
        CFG_PRESSURE_FULL:  cfg_d.pressure_full_cbar  = cfg_wdata_i;
        CFG_TEMP_LIMIT:     cfg_d.temp_limit_ddeg     = cfg_wdata_i[11:0];
        CFG_LOW_VOLTAGE:    cfg_d.low_voltage_mv      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_energy_wh       <= 16'd3000;
      cfg_q.pressure_empty_cbar <= 16'd200;
      cfg_q.pressure_full_cbar  <= 16'd3500;
      cfg_q.temp_limit_ddeg     <= 12'sd800;
      cfg_q.low_voltage_mv      <= 16'd20000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fcem_front u_front (
    .push_i    (push),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .job_o     (q_wdata)
  );

  fcem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  fcem_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_rdata_i  (q_rdata),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

  assign full = q_full;

endmodule

>>> test/fuel_cell_energy_monitor_unit_tb.sv
// ----------------------------------------------------------------------------
// fuel_cell_energy_monitor_unit_tb
// Self-checking bench for the fuel cell energy monitor. Telemetry samples go
// in through the push side in random bursts and gaps, and reports are popped
// on a random stall mask. Each accepted sample is run through a local copy of
// the power window, tank scaling and status logic, and every popped report is
// compared field by field with the oldest prediction. The limits start at
// their defaults and are rewritten between phases once the unit has drained:
// extremes, a full pressure not above empty, and random settings.
// ----------------------------------------------------------------------------
module fuel_cell_energy_monitor_unit_tb;
  import fcem_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 5000000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 210;
  localparam int unsigned SETTLE_CYCLES = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  fcem_in_t             sample    = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  fcem_out_t            report;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [15:0]          cfg_wdata = '0;

  // samples waiting to be pushed and reports still owed by the unit
  fcem_in_t  pending_samples[$];
  fcem_out_t due_reports[$];

  // local copy of the limit registers, reset values
  fcem_cfg_t cfg_now = '{
    max_energy_wh:       16'd3000,
    pressure_empty_cbar: 16'd200,
    pressure_full_cbar:  16'd3500,
    temp_limit_ddeg:     12'sd800,
    low_voltage_mv:      16'd20000
  };

  // local copy of the power window
  logic [POWER_W-1:0] pwr_ring [WINDOW];
  int unsigned        ring_slot = 0;
  int unsigned        ring_fill = 0;
  longint unsigned    ring_sum  = 0;

  // traffic shaping
  bit          steady_send = 1'b0;
  logic [15:0] pop_mask    = 16'hFFFF;
  logic [3:0]  pop_phase   = '0;
  int          burst_left  = 0;
  int          gap_left    = 0;

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  fuel_cell_energy_monitor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_data_i   (sample),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (report),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // report for one sample, advancing the power window
  function automatic fcem_out_t compute_report(fcem_in_t s);
    longint unsigned power;
    longint unsigned avg;
    longint unsigned pct;
    longint unsigned energy;
    longint unsigned secs;
    int              temp;
    int              limit;
    fcem_out_t       r;
    power = (64'(s.voltage_mv) * 64'(s.current_ca)) / POWER_SCALE;

    // oldest entry leaves the sum once the window is full
    if (ring_fill == WINDOW) ring_sum -= pwr_ring[ring_slot];
    else ring_fill++;
    pwr_ring[ring_slot] = power[POWER_W-1:0];
    ring_sum += power;
    ring_slot = (ring_slot + 1 == WINDOW) ? 0 : ring_slot + 1;
    avg = ring_sum / ring_fill;

    // tank level, empty test first
    if (s.pressure_cbar <= cfg_now.pressure_empty_cbar) pct = 0;
    else if (s.pressure_cbar >= cfg_now.pressure_full_cbar) pct = PCT_FULL;
    else pct = (64'(s.pressure_cbar) - 64'(cfg_now.pressure_empty_cbar)) * PCT_FULL /
               (64'(cfg_now.pressure_full_cbar) - 64'(cfg_now.pressure_empty_cbar));
    energy = 64'(cfg_now.max_energy_wh) * pct / PCT_FULL;

    // time left, none at low load
    if (avg <= AVG_MIN_MW) begin
      secs = 0;
    end else begin
      secs = energy * MS_PER_HOUR / avg;
      if (secs > TIME_MAX) secs = TIME_MAX;
    end

    temp  = $signed(s.temperature_ddeg);
    limit = $signed(cfg_now.temp_limit_ddeg);
    r.power_mw            = power[POWER_W-1:0];
    r.avg_power_mw        = avg[POWER_W-1:0];
    r.percent_x100        = pct[PCT_W-1:0];
    r.remaining_energy_wh = energy[ENERGY_W-1:0];
    r.remaining_time_s    = secs[TIME_W-1:0];
    r.temp_alert          = temp > limit;
    if (s.fault_bits != 0) r.status_code = ST_FAULT;
    else if (temp > limit) r.status_code = ST_HIGH_TEMP;
    else if (s.voltage_mv < cfg_now.low_voltage_mv) r.status_code = ST_LOW_VOLTAGE;
    else r.status_code = ST_NORMAL;
    return r;
  endfunction

  // random sample, weighted toward the thresholds of the current limits
  function automatic fcem_in_t random_sample(bit quiet);
    fcem_in_t s;
    s.voltage_mv = 16'($urandom);
    s.current_ca = 16'($urandom);
    if (quiet) begin
      s.voltage_mv = 16'($urandom_range(0, 2000));
      s.current_ca = 16'($urandom_range(0, 150));
    end else if ($urandom_range(0, 3) == 0) begin
      s.voltage_mv = cfg_now.low_voltage_mv + 16'($urandom_range(0, 2)) - 16'd1;
    end
    case ($urandom_range(0, 4))
      0: s.pressure_cbar = cfg_now.pressure_empty_cbar + 16'($urandom_range(0, 2)) - 16'd1;
      1: s.pressure_cbar = cfg_now.pressure_full_cbar + 16'($urandom_range(0, 2)) - 16'd1;
      2: s.pressure_cbar = 16'($urandom_range(cfg_now.pressure_empty_cbar,
                                              cfg_now.pressure_full_cbar));
      default: s.pressure_cbar = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0)
      s.temperature_ddeg = cfg_now.temp_limit_ddeg + 12'($urandom_range(0, 2)) - 12'd1;
    else
      s.temperature_ddeg = 12'($urandom);
    case ($urandom_range(0, 3))
      0, 1: s.fault_bits = '0;
      2: s.fault_bits = 32'd1 << $urandom_range(0, 31);
      default: s.fault_bits = $urandom;
    endcase
    return s;
  endfunction

  task automatic add_sample(logic [15:0] volt, logic [15:0] curr, logic [15:0] pres,
                            logic [11:0] temp, logic [31:0] fault);
    fcem_in_t s;
    s.voltage_mv       = volt;
    s.current_ca       = curr;
    s.pressure_cbar    = pres;
    s.temperature_ddeg = temp;
    s.fault_bits       = fault;
    pending_samples.push_back(s);
  endtask

  // one register write, mirrored into the local limits
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MAX_ENERGY:     cfg_now.max_energy_wh       = value;
      CFG_PRESSURE_EMPTY: cfg_now.pressure_empty_cbar = value;
      CFG_PRESSURE_FULL:  cfg_now.pressure_full_cbar  = value;
      CFG_TEMP_LIMIT:     cfg_now.temp_limit_ddeg     = value[11:0];
      CFG_LOW_VOLTAGE:    cfg_now.low_voltage_mv      = value;
      default: ;
    endcase
  endtask

  // all five limits back to back, spare bits of the temperature word random
  task automatic set_limits(logic [15:0] energy, logic [15:0] p_empty,
                            logic [15:0] p_full, logic [11:0] t_limit,
                            logic [15:0] v_low);
    write_reg(CFG_MAX_ENERGY, energy);
    write_reg(CFG_PRESSURE_EMPTY, p_empty);
    write_reg(CFG_PRESSURE_FULL, p_full);
    write_reg(CFG_TEMP_LIMIT, {4'($urandom), t_limit});
    write_reg(CFG_LOW_VOLTAGE, v_low);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold off until every pushed sample has its report back
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || due_reports.size() != 0 || push);
  endtask

  // sender: bursts of words with random gaps, predicts on every accept
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        due_reports.push_back(compute_report(sample));
        void'(pending_samples.pop_front());
        burst_left--;
        if (!steady_send && burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 6);
            2: gap_left = $urandom_range(10, 120);
            default: gap_left = $urandom_range(150, 400);
          endcase
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        push   <= 1'b1;
        sample <= pending_samples[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: pop follows a rotating stall mask
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pop       <= 1'b0;
      pop_phase <= '0;
    end else begin
      pop       <= pop_mask[pop_phase];
      pop_phase <= pop_phase + 1'b1;
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each popped word with the oldest prediction
  always @(posedge clk) begin : compare_reports
    fcem_out_t want;
    if (rst_n && pop && !empty) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, report);
        mismatch_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("power_mw", want.power_mw, report.power_mw);
        check_field("avg_power_mw", want.avg_power_mw, report.avg_power_mw);
        check_field("percent_x100", want.percent_x100, report.percent_x100);
        check_field("remaining_energy_wh", want.remaining_energy_wh,
                    report.remaining_energy_wh);
        check_field("remaining_time_s", want.remaining_time_s, report.remaining_time_s);
        check_field("status_code", want.status_code, report.status_code);
        check_field("temp_alert", want.temp_alert, report.temp_alert);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int          k;
    int          quiet_pct;
    logic [15:0] lo;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    pop_mask = 16'($urandom) | 16'h0001;

    // reset limits: field extremes, thresholds, window fill and wrap
    add_sample(16'd0, 16'd0, 16'd0, 12'd0, 32'd0);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h7FF, 32'hFFFF_FFFF);
    add_sample(16'hFFFF, 16'hFFFF, 16'd200, 12'd801, 32'd0);
    add_sample(16'd20000, 16'd100, 16'd201, 12'd800, 32'd0);
    add_sample(16'd19999, 16'd100, 16'd3499, 12'h800, 32'd0);
    add_sample(16'd20000, 16'd50, 16'd3500, -12'sd400, 32'd1);
    add_sample(16'd30000, 16'd0, 16'd1850, 12'd2000, 32'h8000_0000);
    // ten words at exactly 1 W flush the window, then one just above
    repeat (10) add_sample(16'd10000, 16'd10, 16'd2000, 12'd0, 32'd0);
    add_sample(16'd10100, 16'd10, 16'd2000, 12'd0, 32'd0);
    // fault over high temp over low voltage
    add_sample(16'd0, 16'd1234, 16'd2500, 12'h7FF, 32'd4);
    add_sample(16'd0, 16'd1234, 16'd2500, 12'd801, 32'd0);
    drain();

    // unused register indexes, then full pressure equal to empty
    for (k = int'(CFG_LOW_VOLTAGE) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 16'($urandom));
    set_limits(16'hFFFF, 16'd5000, 16'd5000, 12'h800, 16'hFFFF);
    add_sample(16'd40000, 16'd900, 16'd4999, 12'h800, 32'd0);
    add_sample(16'd40000, 16'd900, 16'd5000, 12'h801, 32'd0);
    add_sample(16'd40000, 16'd900, 16'd5001, 12'h800, 32'd0);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h7FF, 32'd0);
    drain();

    // random phases, each under its own limits and traffic shape
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_limits(16'd0, 16'd0, 16'd0, 12'h800, 16'd0);
        1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h7FF, 16'hFFFF);
        2: set_limits(16'hFFFF, 16'd0, 16'hFFFF, 12'($urandom), 16'($urandom));
        3: begin
          // full below empty
          lo = 16'($urandom_range(1000, 65535));
          set_limits(16'($urandom), lo, 16'($urandom_range(0, lo - 1)),
                     12'($urandom), 16'($urandom));
        end
        default: begin
          lo = 16'($urandom_range(0, 30000));
          set_limits(16'($urandom), lo, lo + 16'($urandom_range(1, 35535)),
                     12'($urandom), 16'($urandom));
        end
      endcase
      steady_send = (ph == 3 || ph == 6);
      pop_mask    = (ph == 3 || ph == 5) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      quiet_pct   = (ph % 3 == 0) ? 85 : 15;
      repeat (PHASE_ITEMS)
        pending_samples.push_back(random_sample($urandom_range(0, 99) < quiet_pct));
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && due_reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
